// ----- rtl/sprite_quad_vertex_generator_defines.svh -----
// ----------------------------------------------------------------------------
// sprite quad vertex generator assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SQVG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SQVG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sqvg_pkg.sv -----
// ----------------------------------------------------------------------------
// sqvg_pkg
// shared constants, register indexes and cordic arctangent table
// ----------------------------------------------------------------------------
package sqvg_pkg;

   localparam int COORD_W    = 24;
   localparam int TRIG_W     = 18;
   localparam int RATIO_W    = 40;
   localparam int CORDIC_W   = 36;
   localparam int CORDIC_STEPS = 24;

   // register indexes on the csr port
   localparam logic CSR_TEX_WIDTH  = 1'b0;
   localparam logic CSR_TEX_HEIGHT = 1'b1;

   localparam logic [1:0] LAST_CORNER = 2'd3;

   // q30 angle constants
   localparam logic signed [CORDIC_W-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [CORDIC_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [CORDIC_W-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] GAIN_INV    = 36'sd652032874;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/sqvg_div.sv -----
// ----------------------------------------------------------------------------
// sqvg_div
// pipelined unsigned restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
module sqvg_div #(
   parameter int NUM_W  = 34,   // even
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [NUM_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   localparam int STAGES = NUM_W / 2;

   logic              valid_ff [STAGES];
   logic [NUM_W-1:0]  work_ff  [STAGES];
   logic [DEN_W-1:0]  rem_ff   [STAGES];
   logic [DEN_W-1:0]  den_ff   [STAGES];
   logic [SIDE_W-1:0] side_ff  [STAGES];

   logic [NUM_W-1:0]  work_src [STAGES];
   logic [DEN_W-1:0]  rem_src  [STAGES];
   logic [DEN_W-1:0]  den_src  [STAGES];
   logic [NUM_W-1:0]  work_in  [STAGES];
   logic [DEN_W-1:0]  rem_in   [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign work_src[s] = num;
         assign rem_src[s]  = '0;
         assign den_src[s]  = den;
      end else begin : g_next
         assign work_src[s] = work_ff[s-1];
         assign rem_src[s]  = rem_ff[s-1];
         assign den_src[s]  = den_ff[s-1];
      end

      // two restoring steps: dividend bits leave at the top, quotient enters at the bottom
      always_comb begin
         logic [DEN_W:0]   t;
         logic [DEN_W-1:0] r;
         logic [NUM_W-1:0] w;
         logic             ge;
         r = rem_src[s];
         w = work_src[s];
         for (int k = 0; k < 2; k++) begin
            t  = {r, w[NUM_W-1]};
            ge = (t >= {1'b0, den_src[s]});
            r  = ge ? DEN_W'(t - {1'b0, den_src[s]}) : t[DEN_W-1:0];
            w  = {w[NUM_W-2:0], ge};
         end
         rem_in[s]  = r;
         work_in[s] = w;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            work_ff[s] <= work_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_src[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < STAGES; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign quo       = work_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];

endmodule

// ----- rtl/sqvg_cordic.sv -----
// ----------------------------------------------------------------------------
// sqvg_cordic
// pipelined sine and cosine, range reduction, 24 rotation steps, rounding
// ----------------------------------------------------------------------------
module sqvg_cordic #(
   parameter int SIDE_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [15:0]                angle,
   input  logic [SIDE_W-1:0]                 side_in,
   output logic                              out_valid,
   output logic signed [sqvg_pkg::TRIG_W-1:0] sin_q,
   output logic signed [sqvg_pkg::TRIG_W-1:0] cos_q,
   output logic [SIDE_W-1:0]                 side_out
);

   localparam int W           = sqvg_pkg::CORDIC_W;
   localparam int STEP_STAGES = sqvg_pkg::CORDIC_STEPS / 2;
   localparam int STAGES      = STEP_STAGES + 2;

   logic              valid_ff [STAGES];
   logic [SIDE_W-1:0] side_ff  [STAGES];

   // range reduction stage
   logic signed [W-1:0] z_pre_ff, z_pre_in;
   logic                neg_pre_ff, neg_pre_in;
   logic                zero_pre_ff;

   always_comb begin
      logic signed [W-1:0] z0;
      logic signed [W-1:0] zw;
      z0 = {{2{angle[15]}}, angle, 18'b0};
      if (z0 > sqvg_pkg::Q30_PI)       zw = z0 - sqvg_pkg::Q30_TWO_PI;
      else if (z0 < -sqvg_pkg::Q30_PI) zw = z0 + sqvg_pkg::Q30_TWO_PI;
      else                             zw = z0;
      neg_pre_in = 1'b1;
      if (zw > sqvg_pkg::Q30_HALF_PI)       z_pre_in = zw - sqvg_pkg::Q30_PI;
      else if (zw < -sqvg_pkg::Q30_HALF_PI) z_pre_in = zw + sqvg_pkg::Q30_PI;
      else begin
         z_pre_in   = zw;
         neg_pre_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_pre_ff    <= z_pre_in;
         neg_pre_ff  <= neg_pre_in;
         zero_pre_ff <= (angle == 16'sd0);
      end
   end

   // rotation stages
   logic signed [W-1:0] x_ff [STEP_STAGES];
   logic signed [W-1:0] y_ff [STEP_STAGES];
   logic signed [W-1:0] z_ff [STEP_STAGES];
   logic                neg_ff  [STEP_STAGES];
   logic                zero_ff [STEP_STAGES];
   logic signed [W-1:0] x_src [STEP_STAGES];
   logic signed [W-1:0] y_src [STEP_STAGES];
   logic signed [W-1:0] z_src [STEP_STAGES];
   logic                neg_src  [STEP_STAGES];
   logic                zero_src [STEP_STAGES];
   logic signed [W-1:0] x_in [STEP_STAGES];
   logic signed [W-1:0] y_in [STEP_STAGES];
   logic signed [W-1:0] z_in [STEP_STAGES];

   for (genvar s = 0; s < STEP_STAGES; s++) begin : g_rot
      if (s == 0) begin : g_first
         assign x_src[s]    = sqvg_pkg::GAIN_INV;
         assign y_src[s]    = '0;
         assign z_src[s]    = z_pre_ff;
         assign neg_src[s]  = neg_pre_ff;
         assign zero_src[s] = zero_pre_ff;
      end else begin : g_next
         assign x_src[s]    = x_ff[s-1];
         assign y_src[s]    = y_ff[s-1];
         assign z_src[s]    = z_ff[s-1];
         assign neg_src[s]  = neg_ff[s-1];
         assign zero_src[s] = zero_ff[s-1];
      end

      always_comb begin
         logic signed [W-1:0] xa, ya, za, xn, at;
         xa = x_src[s];
         ya = y_src[s];
         za = z_src[s];
         for (int k = 0; k < 2; k++) begin
            at = W'(signed'({1'b0, sqvg_pkg::atan_q30(5'(2 * s + k))}));
            if (!za[W-1]) begin
               xn = xa - (ya >>> (2 * s + k));
               ya = ya + (xa >>> (2 * s + k));
               za = za - at;
            end else begin
               xn = xa + (ya >>> (2 * s + k));
               ya = ya - (xa >>> (2 * s + k));
               za = za + at;
            end
            xa = xn;
         end
         x_in[s] = xa;
         y_in[s] = ya;
         z_in[s] = za;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s]    <= x_in[s];
            y_ff[s]    <= y_in[s];
            z_ff[s]    <= z_in[s];
            neg_ff[s]  <= neg_src[s];
            zero_ff[s] <= zero_src[s];
         end
      end
   end

   // unfold, round to q2.16, exact result for a zero angle
   logic signed [sqvg_pkg::TRIG_W-1:0] sin_ff, sin_in, cos_ff, cos_in;

   always_comb begin
      logic signed [W-1:0] xr, yr;
      xr = neg_ff[STEP_STAGES-1] ? -x_ff[STEP_STAGES-1] : x_ff[STEP_STAGES-1];
      yr = neg_ff[STEP_STAGES-1] ? -y_ff[STEP_STAGES-1] : y_ff[STEP_STAGES-1];
      if (zero_ff[STEP_STAGES-1]) begin
         cos_in = 18'sd65536;
         sin_in = 18'sd0;
      end else begin
         cos_in = sqvg_pkg::TRIG_W'((xr + 36'sd8192) >>> 14);
         sin_in = sqvg_pkg::TRIG_W'((yr + 36'sd8192) >>> 14);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < STAGES; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];
   assign sin_q     = sin_ff;
   assign cos_q     = cos_ff;

endmodule

// ----- rtl/sqvg_pos.sv -----
// ----------------------------------------------------------------------------
// sqvg_pos
// vertex position pipeline: local offset, scale, rotate, translate, saturate
// ----------------------------------------------------------------------------
module sqvg_pos #(
   parameter int SIDE_W = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [1:0]                         corner,
   input  logic signed [sqvg_pkg::COORD_W-1:0] dest_x,
   input  logic signed [sqvg_pkg::COORD_W-1:0] dest_y,
   input  logic signed [sqvg_pkg::COORD_W-1:0] dest_w,
   input  logic signed [sqvg_pkg::COORD_W-1:0] dest_h,
   input  logic signed [sqvg_pkg::RATIO_W-1:0] ratio_x,
   input  logic signed [sqvg_pkg::RATIO_W-1:0] ratio_y,
   input  logic signed [sqvg_pkg::TRIG_W-1:0]  sin_q,
   input  logic signed [sqvg_pkg::TRIG_W-1:0]  cos_q,
   input  logic [SIDE_W-1:0]                  side_in,
   output logic                               out_valid,
   output logic signed [sqvg_pkg::COORD_W-1:0] pos_x,
   output logic signed [sqvg_pkg::COORD_W-1:0] pos_y,
   output logic [SIDE_W-1:0]                  side_out
);

   localparam int STAGES = 6;

   logic              valid_ff [STAGES];
   logic [SIDE_W-1:0] side_ff  [STAGES];

   // stage 1: corner minus origin ratio
   logic signed [40:0] ax_ff, ay_ff;
   logic signed [23:0] dx1_ff, dy1_ff, dw1_ff, dh1_ff;
   logic signed [17:0] sin1_ff, cos1_ff;
   logic               cx, cy;

   assign cx = (corner == 2'd1) || (corner == 2'd2);
   assign cy = corner[1];

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff   <= (cx ? 41'sd65536 : 41'sd0) - 41'(ratio_x);
         ay_ff   <= (cy ? 41'sd65536 : 41'sd0) - 41'(ratio_y);
         dx1_ff  <= dest_x;
         dy1_ff  <= dest_y;
         dw1_ff  <= dest_w;
         dh1_ff  <= dest_h;
         sin1_ff <= sin_q;
         cos1_ff <= cos_q;
      end
   end

   // stage 2: scale by destination size, split into two partial products
   logic signed [41:0] mxl_ff, myl_ff;
   logic signed [47:0] mxh_ff, myh_ff;
   logic signed [23:0] dx2_ff, dy2_ff;
   logic signed [17:0] sin2_ff, cos2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mxl_ff  <= 42'($signed({1'b0, ax_ff[16:0]}) * dw1_ff);
         mxh_ff  <= 48'($signed(ax_ff[40:17]) * dw1_ff);
         myl_ff  <= 42'($signed({1'b0, ay_ff[16:0]}) * dh1_ff);
         myh_ff  <= 48'($signed(ay_ff[40:17]) * dh1_ff);
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         sin2_ff <= sin1_ff;
         cos2_ff <= cos1_ff;
      end
   end

   // stage 3: combine, round to q.8, clamp to +-2^40
   logic signed [41:0] px_ff, px_in, py_ff, py_in;
   logic signed [23:0] dx3_ff, dy3_ff;
   logic signed [17:0] sin3_ff, cos3_ff;

   always_comb begin
      logic signed [65:0] sx, sy;
      logic signed [49:0] rx, ry;
      sx = (66'(mxh_ff) <<< 17) + 66'(mxl_ff);
      sy = (66'(myh_ff) <<< 17) + 66'(myl_ff);
      rx = 50'((sx + 66'sd32768) >>> 16);
      ry = 50'((sy + 66'sd32768) >>> 16);
      if (rx > 50'sd1099511627776)       px_in = 42'sd1099511627776;
      else if (rx < -50'sd1099511627776) px_in = -42'sd1099511627776;
      else                               px_in = 42'(rx);
      if (ry > 50'sd1099511627776)       py_in = 42'sd1099511627776;
      else if (ry < -50'sd1099511627776) py_in = -42'sd1099511627776;
      else                               py_in = 42'(ry);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         sin3_ff <= sin2_ff;
         cos3_ff <= cos2_ff;
      end
   end

   // stage 4: rotation partial products
   logic signed [39:0] xcl_ff, ysl_ff, xsl_ff, ycl_ff;
   logic signed [38:0] xch_ff, ysh_ff, xsh_ff, ych_ff;
   logic signed [23:0] dx4_ff, dy4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xcl_ff <= 40'($signed({1'b0, px_ff[20:0]}) * cos3_ff);
         xch_ff <= 39'($signed(px_ff[41:21]) * cos3_ff);
         ysl_ff <= 40'($signed({1'b0, py_ff[20:0]}) * sin3_ff);
         ysh_ff <= 39'($signed(py_ff[41:21]) * sin3_ff);
         xsl_ff <= 40'($signed({1'b0, px_ff[20:0]}) * sin3_ff);
         xsh_ff <= 39'($signed(px_ff[41:21]) * sin3_ff);
         ycl_ff <= 40'($signed({1'b0, py_ff[20:0]}) * cos3_ff);
         ych_ff <= 39'($signed(py_ff[41:21]) * cos3_ff);
         dx4_ff <= dx3_ff;
         dy4_ff <= dy3_ff;
      end
   end

   // stage 5: full rotation terms
   logic signed [61:0] txc_ff, tys_ff, txs_ff, tyc_ff;
   logic signed [23:0] dx5_ff, dy5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         txc_ff <= (62'(xch_ff) <<< 21) + 62'(xcl_ff);
         tys_ff <= (62'(ysh_ff) <<< 21) + 62'(ysl_ff);
         txs_ff <= (62'(xsh_ff) <<< 21) + 62'(xsl_ff);
         tyc_ff <= (62'(ych_ff) <<< 21) + 62'(ycl_ff);
         dx5_ff <= dx4_ff;
         dy5_ff <= dy4_ff;
      end
   end

   // stage 6: translate, round, saturate
   logic signed [23:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;

   always_comb begin
      logic signed [61:0] vx, vy;
      vx = (62'(dx5_ff) <<< 16) + txc_ff - tys_ff;
      vy = (62'(dy5_ff) <<< 16) + txs_ff + tyc_ff;
      vx = (vx + 62'sd32768) >>> 16;
      vy = (vy + 62'sd32768) >>> 16;
      if (vx > 62'sd8388607)       pos_x_in = 24'sd8388607;
      else if (vx < -62'sd8388608) pos_x_in = -24'sd8388608;
      else                         pos_x_in = 24'(vx);
      if (vy > 62'sd8388607)       pos_y_in = 24'sd8388607;
      else if (vy < -62'sd8388608) pos_y_in = -24'sd8388608;
      else                         pos_y_in = 24'(vy);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < STAGES; s++) side_ff[s] <= side_ff[s-1];
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign side_out  = side_ff[STAGES-1];
   assign pos_x     = pos_x_ff;
   assign pos_y     = pos_y_ff;

endmodule

// ----- rtl/sprite_quad_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// sprite_quad_vertex_generator
// turns one sprite transaction into four rotated, textured quad vertices
// ----------------------------------------------------------------------------
// path: a sprite passes the cordic, the origin dividers, the issue stage, the
//   position pipeline and the texture dividers; its four vertices leave back
//   to back while rsp_tready stays high. the issue stage sends one vertex per
//   cycle into the vertex pipeline unless that pipeline is held
// reset: synchronous, clears all valid bits and the issue stage, sets both
//   texture size registers to 1
// ----------------------------------------------------------------------------
module sprite_quad_vertex_generator (
   input  logic         clock,
   input  logic         reset,
   // sprite transaction, fields from bit 0 up: dest_x, dest_y, dest_width,
   // dest_height, src_x, src_y, src_width, src_height, origin_x, origin_y,
   // angle, mode_bits
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [263:0] req_tdata,
   // vertex transaction, fields from bit 0 up: pos_x, pos_y, tex_u, tex_v,
   // corner_index, zero fill
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,
   output logic [3:0]   rsp_tuser,   // swizzle
   output logic         rsp_tlast,
   // configuration writes
   input  logic         csr_wen,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   localparam int CSIDE_W = 248;                       // all fields but the angle
   localparam int XSIDE_W = 2 * sqvg_pkg::TRIG_W + CSIDE_W + 1;
   localparam int PSIDE_W = 74;                        // tex numerators, swizzle, corner

   // ---------------------------------------------------------------- csr regs
   logic [15:0] texw_ff, texh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         texw_ff <= 16'd1;
         texh_ff <= 16'd1;
      end else if (csr_wen) begin
         case (csr_index)
            sqvg_pkg::CSR_TEX_WIDTH:  texw_ff <= csr_wdata;
            sqvg_pkg::CSR_TEX_HEIGHT: texh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------ sprite pipeline
   logic en_a;          // sprite pipeline advance
   logic en_v;          // vertex pipeline advance

   logic                      cor_valid;
   logic signed [17:0]        cor_sin, cor_cos;
   logic [CSIDE_W-1:0]        cor_side;

   // sine and cosine first, the remaining fields ride along
   sqvg_cordic #(.SIDE_W(CSIDE_W)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en_a),
      .in_valid  (req_tvalid),
      .angle     (req_tdata[255:240]),
      .side_in   ({req_tdata[263:256], req_tdata[239:0]}),
      .out_valid (cor_valid),
      .sin_q     (cor_sin),
      .cos_q     (cor_cos),
      .side_out  (cor_side)
   );

   // origin ratio: |origin| * 65536 / size, sign put back afterwards
   logic signed [23:0] c_ox, c_oy;
   logic [23:0]        c_sw, c_sh, ox_mag, oy_mag, den_x, den_y;

   assign c_ox   = cor_side[215:192];
   assign c_oy   = cor_side[239:216];
   assign c_sw   = cor_side[167:144];
   assign c_sh   = cor_side[191:168];
   assign ox_mag = c_ox[23] ? 24'(-c_ox) : c_ox;
   assign oy_mag = c_oy[23] ? 24'(-c_oy) : c_oy;
   // a zero source size divides by one lsb
   assign den_x  = (c_sw == 24'd0) ? 24'd1 : c_sw;
   assign den_y  = (c_sh == 24'd0) ? 24'd1 : c_sh;

   logic                dvx_valid, dvy_valid, item_valid;
   logic [39:0]         qx, qy;
   logic [XSIDE_W-1:0]  dvx_side;
   logic                dvy_side;

   sqvg_div #(.NUM_W(sqvg_pkg::RATIO_W), .DEN_W(24), .SIDE_W(XSIDE_W)) u_div_ox (
      .clock     (clock),
      .reset     (reset),
      .en        (en_a),
      .in_valid  (cor_valid),
      .num       ({ox_mag, 16'b0}),
      .den       (den_x),
      .side_in   ({cor_sin, cor_cos, cor_side, c_ox[23]}),
      .out_valid (dvx_valid),
      .quo       (qx),
      .side_out  (dvx_side)
   );

   sqvg_div #(.NUM_W(sqvg_pkg::RATIO_W), .DEN_W(24), .SIDE_W(1)) u_div_oy (
      .clock     (clock),
      .reset     (reset),
      .en        (en_a),
      .in_valid  (cor_valid),
      .num       ({oy_mag, 16'b0}),
      .den       (den_y),
      .side_in   (c_oy[23]),
      .out_valid (dvy_valid),
      .quo       (qy),
      .side_out  (dvy_side)
   );

   assign item_valid = dvx_valid & dvy_valid;

   // ---------------------------------------------------------- vertex issue
   logic                exp_valid_ff, exp_valid_in;
   logic [1:0]          exp_cnt_ff, exp_cnt_in;
   logic signed [23:0]  e_dx_ff, e_dy_ff, e_dw_ff, e_dh_ff;
   logic [23:0]         e_sx_ff, e_sy_ff, e_sw_ff, e_sh_ff;
   logic signed [39:0]  e_rx_ff, e_ry_ff;
   logic signed [17:0]  e_sin_ff, e_cos_ff;
   logic [7:0]          e_mode_ff;
   logic                exp_take, exp_done, load;
   logic [CSIDE_W-1:0]  x_fields;

   assign x_fields = dvx_side[CSIDE_W:1];
   assign exp_take = en_v & exp_valid_ff;
   assign exp_done = exp_take & (exp_cnt_ff == sqvg_pkg::LAST_CORNER);
   // the sprite pipeline moves unless a finished sprite waits on a busy issue stage
   assign en_a     = !item_valid || !exp_valid_ff || exp_done;
   assign load     = en_a & item_valid;
   assign req_tready = en_a;

   always_comb begin
      exp_valid_in = exp_valid_ff;
      exp_cnt_in   = exp_cnt_ff;
      if (exp_take) exp_cnt_in = 2'(exp_cnt_ff + 2'd1);
      if (exp_done) exp_valid_in = 1'b0;
      if (load) begin
         exp_valid_in = 1'b1;
         exp_cnt_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_valid_ff <= 1'b0;
         exp_cnt_ff   <= 2'd0;
      end else begin
         exp_valid_ff <= exp_valid_in;
         exp_cnt_ff   <= exp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         e_dx_ff   <= x_fields[23:0];
         e_dy_ff   <= x_fields[47:24];
         e_dw_ff   <= x_fields[71:48];
         e_dh_ff   <= x_fields[95:72];
         e_sx_ff   <= x_fields[119:96];
         e_sy_ff   <= x_fields[143:120];
         e_sw_ff   <= x_fields[167:144];
         e_sh_ff   <= x_fields[191:168];
         e_mode_ff <= x_fields[247:240];
         e_cos_ff  <= dvx_side[CSIDE_W+18:CSIDE_W+1];
         e_sin_ff  <= dvx_side[CSIDE_W+36:CSIDE_W+19];
         // quotient magnitude, truncated toward zero, sign restored
         e_rx_ff   <= dvx_side[0] ? 40'(-qx) : qx;
         e_ry_ff   <= dvy_side ? 40'(-qy) : qy;
      end
   end

   // texture corner: flip by xor, then quarter turns
   logic [1:0]  tex_corner;
   logic        tcx, tcy;
   logic [33:0] num_u, num_v;

   assign tex_corner = 2'((exp_cnt_ff ^ e_mode_ff[1:0]) + e_mode_ff[3:2]);
   assign tcx   = (tex_corner == 2'd1) || (tex_corner == 2'd2);
   assign tcy   = tex_corner[1];
   assign num_u = {1'b0, 25'(e_sx_ff) + (tcx ? 25'(e_sw_ff) : 25'd0), 8'b0};
   assign num_v = {1'b0, 25'(e_sy_ff) + (tcy ? 25'(e_sh_ff) : 25'd0), 8'b0};

   // ------------------------------------------------------- vertex pipeline
   logic                pos_valid;
   logic signed [23:0]  pos_x, pos_y;
   logic [PSIDE_W-1:0]  pos_side;

   sqvg_pos #(.SIDE_W(PSIDE_W)) u_pos (
      .clock     (clock),
      .reset     (reset),
      .en        (en_v),
      .in_valid  (exp_valid_ff),
      .corner    (exp_cnt_ff),
      .dest_x    (e_dx_ff),
      .dest_y    (e_dy_ff),
      .dest_w    (e_dw_ff),
      .dest_h    (e_dh_ff),
      .ratio_x   (e_rx_ff),
      .ratio_y   (e_ry_ff),
      .sin_q     (e_sin_ff),
      .cos_q     (e_cos_ff),
      .side_in   ({num_u, num_v, e_mode_ff[7:4], exp_cnt_ff}),
      .out_valid (pos_valid),
      .pos_x     (pos_x),
      .pos_y     (pos_y),
      .side_out  (pos_side)
   );

   // a zero texture size register divides by one
   logic [15:0] den_u, den_v;
   assign den_u = (texw_ff == 16'd0) ? 16'd1 : texw_ff;
   assign den_v = (texh_ff == 16'd0) ? 16'd1 : texh_ff;

   logic        tu_valid, tv_valid;
   logic [33:0] qu, qv;
   logic [47:0] tu_side;
   logic [5:0]  tv_side;

   sqvg_div #(.NUM_W(34), .DEN_W(16), .SIDE_W(48)) u_div_u (
      .clock     (clock),
      .reset     (reset),
      .en        (en_v),
      .in_valid  (pos_valid),
      .num       (pos_side[73:40]),
      .den       (den_u),
      .side_in   ({pos_y, pos_x}),
      .out_valid (tu_valid),
      .quo       (qu),
      .side_out  (tu_side)
   );

   sqvg_div #(.NUM_W(34), .DEN_W(16), .SIDE_W(6)) u_div_v (
      .clock     (clock),
      .reset     (reset),
      .en        (en_v),
      .in_valid  (pos_valid),
      .num       (pos_side[39:6]),
      .den       (den_v),
      .side_in   (pos_side[5:0]),
      .out_valid (tv_valid),
      .quo       (qv),
      .side_out  (tv_side)
   );

   // ------------------------------------------------------------ result port
   logic [23:0] tex_u, tex_v;
   assign tex_u = (qu[33:24] != 10'd0) ? 24'hFFFFFF : qu[23:0];
   assign tex_v = (qv[33:24] != 10'd0) ? 24'hFFFFFF : qv[23:0];

   assign rsp_tvalid = tu_valid & tv_valid;
   // whole vertex pipeline holds while a vertex waits on the consumer
   assign en_v       = !rsp_tvalid || rsp_tready;
   assign rsp_tdata  = {6'b0, tv_side[1:0], tex_v, tex_u, tu_side};
   assign rsp_tuser  = tv_side[5:2];
   assign rsp_tlast  = (tv_side[1:0] == sqvg_pkg::LAST_CORNER);

endmodule

// ----- rtl/sqvg_checker.sv -----
// ----------------------------------------------------------------------------
// sqvg_checker
// port-level checks on the vertex result stream
// ----------------------------------------------------------------------------
`include "sprite_quad_vertex_generator_defines.svh"

module sqvg_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic [3:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // a stalled vertex stays put
   `SQVG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled vertex changed")

   // last flag marks corner three only
   `SQVG_ASSERT_IMP(a_last_corner, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[97:96] == 2'd3), "last flag and corner disagree")

   // the four vertices of a sprite come back to back
   `SQVG_ASSERT_NXT(a_quad_burst, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "gap inside a quad")

   // corners count up within a sprite
   `SQVG_ASSERT_NXT(a_corner_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tdata[97:96] == 2'($past(rsp_tdata[97:96]) + 2'd1), "corner order broken")

endmodule

bind sprite_quad_vertex_generator sqvg_checker u_sqvg_checker (.*);
